### hdl/sle_pkg.sv
package sle_pkg;

  localparam int CAPACITY  = 16;
  localparam int KEY_W     = 32;
  localparam int KEY_IN_W  = 32;
  localparam int POS_W     = 4;
  localparam int OUT_CNT_W = 5;
  localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  // common width for comparing positions with indexes and counts
  localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam int S_DATA_W  = 40;
  localparam int S_USER_W  = 2;
  localparam int M_DATA_W  = 40;

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_READ     = 2'd1,
    CMD_CONTAINS = 2'd2,
    CMD_ERASE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // broadcast to every cell in the chain
  typedef struct packed {
    logic             insert_en;
    logic             erase_en;
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] pos;
    logic [CNT_W-1:0] count;
  } cell_ctrl_t;

endpackage

### hdl/sle_cell.sv
module sle_cell (
  input  logic                      clk,
  input  sle_pkg::cell_ctrl_t       ctrl,
  input  logic [sle_pkg::IDX_W-1:0] idx,
  input  logic [sle_pkg::KEY_W-1:0] left_key,
  input  logic                      left_gt,
  input  logic                      left_open,
  input  logic [sle_pkg::KEY_W-1:0] right_key,
  output logic [sle_pkg::KEY_W-1:0] key,
  output logic                      gt,
  output logic                      open,
  output logic                      match
);

  logic                      occupied;
  logic                      at_or_after;
  logic [sle_pkg::KEY_W-1:0] key_next;

  assign occupied    = sle_pkg::CNT_W'(idx) < ctrl.count;
  assign at_or_after = sle_pkg::CMP_W'(idx) >= sle_pkg::CMP_W'(ctrl.pos);
  assign gt          = occupied && (ctrl.key < key);
  // a free slot or one holding a greater key is open; the first open slot takes the new key
  assign open        = gt || !occupied;
  assign match       = occupied && (ctrl.key == key);

  always_comb begin
    key_next = key;
    if (ctrl.insert_en) begin
      if (left_gt) begin
        key_next = left_key;
      end else if (open && !left_open) begin
        key_next = ctrl.key;
      end
    end else if (ctrl.erase_en && at_or_after) begin
      key_next = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
  end

endmodule

### hdl/sle_chain.sv
module sle_chain (
  input  logic                      clk,
  input  sle_pkg::cell_ctrl_t       ctrl,
  output logic [sle_pkg::KEY_W-1:0] rd_key,
  output logic                      hit
);

  logic [sle_pkg::KEY_W-1:0]    keys  [sle_pkg::CAPACITY];
  logic [sle_pkg::CAPACITY-1:0] gts;
  logic [sle_pkg::CAPACITY-1:0] opens;
  logic [sle_pkg::CAPACITY-1:0] eq_bits;

  for (genvar i = 0; i < sle_pkg::CAPACITY; i++) begin : g_cell
    logic [sle_pkg::KEY_W-1:0] lk;
    logic [sle_pkg::KEY_W-1:0] rk;
    logic                      lg;
    logic                      lo;
    if (i == 0) begin : g_head
      assign lk = keys[i];
      assign lg = 1'b0;
      assign lo = 1'b0;
    end else begin : g_mid
      assign lk = keys[i-1];
      assign lg = gts[i-1];
      assign lo = opens[i-1];
    end
    if (i == sle_pkg::CAPACITY - 1) begin : g_tail
      assign rk = keys[i];
    end else begin : g_body
      assign rk = keys[i+1];
    end
    sle_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .idx       (sle_pkg::IDX_W'(i)),
      .left_key  (lk),
      .left_gt   (lg),
      .left_open (lo),
      .right_key (rk),
      .key       (keys[i]),
      .gt        (gts[i]),
      .open      (opens[i]),
      .match     (eq_bits[i])
    );
  end

  assign rd_key = keys[sle_pkg::IDX_W'(ctrl.pos)];
  assign hit    = |eq_bits;

endmodule

### hdl/sorted_list_engine.sv
// channel   dir  bits  fields (lowest bit up)
// s_axis    in   40+2  tdata: key[31:0] position[35:32]; tuser: cmd[1:0]
// m_axis    out  40    tdata: read_key[31:0] found[32] status[34:33] entry_count[39:35]
//
// one command per cycle: each cell compares against the broadcast key at once and
// shifts with its neighbour in the same cycle, so the list is updated at the transfer
// result sits in one output register; a new command is taken while it drains
// rst (synchronous) empties the list; stored keys are not cleared
// input stalls in reset and while a result waits and the output side holds tready low
module sorted_list_engine (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [sle_pkg::S_DATA_W-1:0] s_tdata,  // key[31:0] position[35:32]
  input  logic [sle_pkg::S_USER_W-1:0] s_tuser,  // cmd[1:0]
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [sle_pkg::M_DATA_W-1:0] m_tdata   // read_key found status entry_count
);

  logic                          s_xfer;
  sle_pkg::cmd_t                 cmd;
  logic [sle_pkg::KEY_IN_W-1:0]  key_in;
  logic [sle_pkg::POS_W-1:0]     pos;
  logic [sle_pkg::CNT_W-1:0]     count;
  logic [sle_pkg::CNT_W-1:0]     count_next;
  logic                          in_range;
  logic                          full;
  sle_pkg::cell_ctrl_t           ctrl;
  logic [sle_pkg::KEY_W-1:0]     rd_key;
  logic                          hit;

  logic [sle_pkg::KEY_IN_W-1:0]  res_key;
  logic                          res_found;
  sle_pkg::status_t              res_status;
  logic [sle_pkg::M_DATA_W-1:0]  m_tdata_next;

  assign s_tready = !rst && (!m_tvalid || m_tready);
  assign s_xfer   = s_tvalid && s_tready;

  // unpack the incoming transfer
  assign cmd    = sle_pkg::cmd_t'(s_tuser[1:0]);
  assign key_in = s_tdata[sle_pkg::KEY_IN_W-1:0];
  assign pos    = s_tdata[sle_pkg::KEY_IN_W +: sle_pkg::POS_W];

  assign in_range = sle_pkg::CMP_W'(pos) < sle_pkg::CMP_W'(count);
  assign full     = count == sle_pkg::CNT_W'(sle_pkg::CAPACITY);

  always_comb begin
    ctrl.insert_en = s_xfer && (cmd == sle_pkg::CMD_INSERT) && !full;
    ctrl.erase_en  = s_xfer && (cmd == sle_pkg::CMD_ERASE) && in_range;
    ctrl.key       = sle_pkg::KEY_W'(key_in);
    ctrl.pos       = pos;
    ctrl.count     = count;
  end

  sle_chain u_chain (
    .clk    (clk),
    .ctrl   (ctrl),
    .rd_key (rd_key),
    .hit    (hit)
  );

  always_comb begin
    count_next = count;
    if (ctrl.insert_en) begin
      count_next = count + sle_pkg::CNT_W'(1);
    end else if (ctrl.erase_en) begin
      count_next = count - sle_pkg::CNT_W'(1);
    end
  end

  // result fields for the command being transferred
  always_comb begin
    res_key    = '0;
    res_found  = 1'b0;
    res_status = sle_pkg::ST_OK;
    case (cmd)
      sle_pkg::CMD_INSERT: begin
        res_found  = !full;
        res_status = full ? sle_pkg::ST_FULL : sle_pkg::ST_OK;
      end
      sle_pkg::CMD_READ: begin
        res_found  = in_range;
        res_status = in_range ? sle_pkg::ST_OK : sle_pkg::ST_RANGE;
        res_key    = in_range ? sle_pkg::KEY_IN_W'(rd_key) : '0;
      end
      sle_pkg::CMD_CONTAINS: begin
        res_found = hit;
      end
      sle_pkg::CMD_ERASE: begin
        res_found  = in_range;
        res_status = in_range ? sle_pkg::ST_OK : sle_pkg::ST_RANGE;
      end
      default: begin
        res_found = 1'b0;
      end
    endcase
  end

  assign m_tdata_next = {sle_pkg::OUT_CNT_W'(count_next), res_status, res_found, res_key};

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (s_xfer) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (s_xfer) begin
      m_tdata <= m_tdata_next;
    end
  end

  // list never holds more than its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= sle_pkg::CNT_W'(sle_pkg::CAPACITY))
    else $error("entry count above capacity");

  // a refused insert leaves the list alone
  a_full_insert: assert property (@(posedge clk) disable iff (rst)
    (s_xfer && cmd == sle_pkg::CMD_INSERT && full) |=> $stable(count))
    else $error("count changed on a refused insert");

  // every accepted command yields a result in the next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    s_xfer |=> m_tvalid)
    else $error("accepted command without result");

  // count only moves on an accepted command
  a_count_moves: assert property (@(posedge clk) disable iff (rst)
    !s_xfer |=> $stable(count))
    else $error("count changed without a transfer");

endmodule
